>>> rtl/toa_pkg.sv
// ----------------------------------------------------------------------------
// toa_pkg: shared types and constants for the LoRa time-on-air block
// Settings group, sideband record, divider geometry and reciprocal table.
// ----------------------------------------------------------------------------
`default_nettype none

package toa_pkg;

  // divide-by-125 pipeline: 4 quotient bits per stage over a 40-bit word
  localparam int DIV_W      = 40;
  localparam int DIGIT_W    = 4;
  localparam int DIV_STAGES = DIV_W / DIGIT_W;
  localparam int REM_W      = 7;

  // 1e9 ns / (100 * bw_tenth_khz) = 1e7 / bw_tenth_khz
  localparam logic [35:0] NS_SCALE     = 36'd10000000;
  localparam logic [35:0] LDRO_NS      = 36'd16000000;
  localparam logic [53:0] US_SAT_LIMIT = 54'd4294967296000;
  localparam logic [53:0] ROUND_NS     = 54'd500;
  localparam logic [32:0] ROUND_US     = 33'd500;
  localparam logic [4:0]  PRE_FRAC     = 5'd17;
  localparam logic [5:0]  DIV_LAST     = 6'd35;
  localparam logic [4:0]  MUL_LAST     = 5'd18;

  typedef enum logic [1:0] {ST_LOAD, ST_DIV, ST_MUL, ST_READY} toa_state_t;

  typedef enum logic [2:0] {
    REG_SF, REG_BW, REG_CR, REG_PRE, REG_EXPL, REG_CRC
  } toa_reg_t;

  // settings and derived values handed to the item pipeline
  typedef struct packed {
    logic [3:0]  sf;
    logic [3:0]  k;        // sf - 2*ldro
    logic [3:0]  cr;
    logic        crc;
    logic        expl;
    logic        ldro;
    logic        invalid;
    logic [35:0] tsym;     // symbol period, ns
    logic [51:0] pre_ns;   // preamble duration, ns
    logic        busy;
  } toa_cfg_t;

  // per-item sideband through the dividers
  typedef struct packed {
    logic [31:0] us;
    logic        ldro;
    logic        invalid;
    logic        sat;
  } toa_side_t;

  // ceil(2^18 / k); floor(n / (4k)) = (n * recip) >> 20 for n < 4096
  function automatic logic [16:0] toa_recip(input logic [3:0] k);
    logic [16:0] r;
    case (k)
      4'd3:    r = 17'd87382;
      4'd4:    r = 17'd65536;
      4'd5:    r = 17'd52429;
      4'd6:    r = 17'd43691;
      4'd7:    r = 17'd37450;
      4'd8:    r = 17'd32768;
      4'd9:    r = 17'd29128;
      4'd10:   r = 17'd26215;
      4'd11:   r = 17'd23832;
      4'd12:   r = 17'd21846;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lora_time_on_air.sv
// ----------------------------------------------------------------------------
// lora_time_on_air: LoRa packet time on air
// Payload length in, time on air in microseconds and milliseconds out.
// ----------------------------------------------------------------------------
//  port group  dir  payload
//  in_*        in   tdata[7:0] payload_bytes
//  out_*       out  tdata[31:0] time_us, [54:32] time_ms; tuser ldro, invalid
//  cfg_*       in   index 0..5, data 16 bits
//
// One beat per cycle unless an output stall or the settings sequencer holds it; the path is
// 5 front stages, two 10-stage divide-by-125 pipes, microsecond stage, output register.
// After reset and after each settings write the derived-value sequencer runs
// with in_tready low; with invalid settings it skips the divide and multiply.
// An output stall holds every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module lora_time_on_air (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] payload_bytes
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,   // [31:0] time_us, [54:32] time_ms, [55] zero
  output logic [1:0]       out_tuser,   // [0] ldro_active, [1] settings_invalid
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  toa_pkg::toa_cfg_t  cfg;
  logic               en;
  logic               f_valid;
  logic [toa_pkg::DIV_W-1:0] f_x;
  toa_pkg::toa_side_t f_side;
  logic               d1_valid;
  logic [toa_pkg::DIV_W-1:0] d1_q;
  toa_pkg::toa_side_t d1_side;
  logic               us_valid_r;
  logic [toa_pkg::DIV_W-1:0] x2_r;
  toa_pkg::toa_side_t side2_r;
  logic               d2_valid;
  logic [toa_pkg::DIV_W-1:0] d2_q;
  toa_pkg::toa_side_t d2_side;
  logic [31:0]        us;
  logic [32:0]        us_rnd;
  logic               out_valid_r;
  logic [55:0]        out_data_r;
  logic [1:0]         out_user_r;

  // whole pipe advances when the output register can take a beat
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && !cfg.busy;

  toa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  toa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_tvalid && in_tready),
    .payload_bytes (in_tdata),
    .cfg           (cfg),
    .out_valid     (f_valid),
    .out_x         (f_x),
    .out_side      (f_side)
  );

  toa_div125 u_div_us (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_x      (f_x),
    .in_side   (f_side),
    .out_valid (d1_valid),
    .out_q     (d1_q),
    .out_side  (d1_side)
  );

  // microseconds with saturation, then half a millisecond for rounding
  assign us     = d1_side.sat ? 32'hFFFF_FFFF : d1_q[31:0];
  assign us_rnd = {1'b0, us} + toa_pkg::ROUND_US;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      us_valid_r <= 1'b0;
    end else if (en) begin
      us_valid_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r    <= {10'd0, us_rnd[32:3]};
      side2_r <= '{us: us, ldro: d1_side.ldro, invalid: d1_side.invalid,
                   sat: d1_side.sat};
    end
  end

  toa_div125 u_div_ms (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (us_valid_r),
    .in_x      (x2_r),
    .in_side   (side2_r),
    .out_valid (d2_valid),
    .out_q     (d2_q),
    .out_side  (d2_side)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d2_side.invalid) begin
        out_data_r <= 56'd0;
        out_user_r <= 2'b10;
      end else begin
        out_data_r <= {1'b0, d2_q[22:0], d2_side.us};
        out_user_r <= {1'b0, d2_side.ldro};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // invalid settings give an all-zero result without the LDRO flag
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tdata == 56'd0) && !out_tuser[0])
    else $error("invalid settings with nonzero result");

  // saturated microseconds pin the millisecond value
  a_sat_ms: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:0] == 32'hFFFF_FFFF) |-> (out_tdata[54:32] == 23'd4294967))
    else $error("saturated time_us with wrong time_ms");

  // a settings write blocks input while derived values are rebuilt
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input accepted right after settings write");

endmodule

`default_nettype wire

>>> rtl/toa_cfg.sv
// ----------------------------------------------------------------------------
// toa_cfg: settings registers and derived-value sequencer
// Holds the six settings; after reset or any write it recomputes the symbol
// period (36-step restoring divide) and the preamble time (19-step multiply).
// ----------------------------------------------------------------------------
`default_nettype none

module toa_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata,
  output toa_pkg::toa_cfg_t      cfg_o
);

  logic [3:0]  sf_r;
  logic [12:0] bw_r;
  logic [3:0]  cr_r;
  logic [15:0] pre_r;
  logic        expl_r;
  logic        crc_r;

  toa_pkg::toa_state_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [35:0] dvd_r, dvd_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [35:0] quo_r, quo_nxt;
  logic [53:0] mc_r, mc_nxt;
  logic [18:0] mp_r, mp_nxt;
  logic [53:0] acc_r, acc_nxt;

  logic        invalid;
  logic        ldro;
  logic [13:0] trial;
  logic        ge;

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r   <= 4'd7;
      bw_r   <= 13'd1250;
      cr_r   <= 4'd5;
      pre_r  <= 16'd8;
      expl_r <= 1'b1;
      crc_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        toa_pkg::REG_SF:   sf_r   <= cfg_wdata[3:0];
        toa_pkg::REG_BW:   bw_r   <= cfg_wdata[12:0];
        toa_pkg::REG_CR:   cr_r   <= cfg_wdata[3:0];
        toa_pkg::REG_PRE:  pre_r  <= cfg_wdata;
        toa_pkg::REG_EXPL: expl_r <= cfg_wdata[0];
        toa_pkg::REG_CRC:  crc_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign invalid = (sf_r < 4'd5) || (sf_r > 4'd12) || (cr_r < 4'd5) ||
                   (cr_r > 4'd8) || (bw_r == 13'd0);

  // one divide step
  assign trial = {rem_r[12:0], dvd_r[35]};
  assign ge    = (trial >= {1'b0, bw_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      toa_pkg::ST_LOAD:  state_nxt = invalid ? toa_pkg::ST_READY : toa_pkg::ST_DIV;
      toa_pkg::ST_DIV:   if (cnt_r == toa_pkg::DIV_LAST) state_nxt = toa_pkg::ST_MUL;
      toa_pkg::ST_MUL:   if (cnt_r[4:0] == toa_pkg::MUL_LAST) state_nxt = toa_pkg::ST_READY;
      toa_pkg::ST_READY: state_nxt = toa_pkg::ST_READY;
      default:           state_nxt = toa_pkg::ST_LOAD;
    endcase
    if (cfg_we) state_nxt = toa_pkg::ST_LOAD;
  end

  // datapath updates per state
  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    mc_nxt  = mc_r;
    mp_nxt  = mp_r;
    acc_nxt = acc_r;
    case (state_r)
      toa_pkg::ST_LOAD: begin
        cnt_nxt = 6'd0;
        dvd_nxt = toa_pkg::NS_SCALE << sf_r;
        rem_nxt = 14'd0;
        quo_nxt = 36'd0;
      end
      toa_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        dvd_nxt = {dvd_r[34:0], 1'b0};
        rem_nxt = ge ? (trial - {1'b0, bw_r}) : trial;
        quo_nxt = {quo_r[34:0], ge};
        if (cnt_r == toa_pkg::DIV_LAST) begin
          cnt_nxt = 6'd0;
          mc_nxt  = {18'd0, quo_r[34:0], ge};
          mp_nxt  = {1'b0, pre_r, 2'b00} + 19'(toa_pkg::PRE_FRAC);
          acc_nxt = 54'd0;
        end
      end
      toa_pkg::ST_MUL: begin
        cnt_nxt = cnt_r + 6'd1;
        acc_nxt = mp_r[0] ? (acc_r + mc_r) : acc_r;
        mc_nxt  = {mc_r[52:0], 1'b0};
        mp_nxt  = {1'b0, mp_r[18:1]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= toa_pkg::ST_LOAD;
      cnt_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    acc_r <= acc_nxt;
  end

  // outputs
  assign ldro = (quo_r >= toa_pkg::LDRO_NS);

  always_comb begin
    cfg_o.sf      = sf_r;
    cfg_o.k       = sf_r - {2'b00, ldro, 1'b0};
    cfg_o.cr      = cr_r;
    cfg_o.crc     = crc_r;
    cfg_o.expl    = expl_r;
    cfg_o.ldro    = ldro;
    cfg_o.invalid = invalid;
    cfg_o.tsym    = quo_r;
    cfg_o.pre_ns  = acc_r[53:2];
    cfg_o.busy    = (state_r != toa_pkg::ST_READY);
  end

endmodule

`default_nettype wire

>>> rtl/toa_front.sv
// ----------------------------------------------------------------------------
// toa_front: payload symbol count and total nanoseconds
// Five stages: ceiling numerator, reciprocal product, symbol count,
// payload time, total with rounding offset and saturation check.
// ----------------------------------------------------------------------------
`default_nettype none

module toa_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [7:0]               payload_bytes,
  input  wire toa_pkg::toa_cfg_t        cfg,
  output logic                          out_valid,
  output logic [toa_pkg::DIV_W-1:0]     out_x,
  output toa_pkg::toa_side_t            out_side
);

  logic [4:0]  v_r;
  logic [11:0] n_r;
  logic [28:0] prod_r;
  logic [10:0] nsyms_r;
  logic [46:0] pay_r;
  logic [toa_pkg::DIV_W-1:0] x_r;
  toa_pkg::toa_side_t side_r [5];

  logic [11:0] pos;
  logic [6:0]  neg;
  logic [11:0] n_nxt;
  logic [53:0] total;
  toa_pkg::toa_side_t side_in;

  // numerator: 8*PL + 28 + 16*CRC versus 4*SF + 20*IH
  assign pos = {1'b0, payload_bytes, 3'b000} + 12'd28 + {7'd0, cfg.crc, 4'd0};
  assign neg = {1'b0, cfg.sf, 2'b00} + (cfg.expl ? 7'd0 : 7'd20);
  assign n_nxt = (pos > {5'd0, neg}) ?
                 (pos - {5'd0, neg} + {6'd0, cfg.k, 2'b00} - 12'd1) : 12'd0;

  assign total = {2'b00, cfg.pre_ns} + {7'd0, pay_r} + toa_pkg::ROUND_NS;

  always_comb begin
    side_in.us      = 32'd0;
    side_in.ldro    = cfg.ldro;
    side_in.invalid = cfg.invalid;
    side_in.sat     = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 5'd0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      n_r       <= n_nxt;
      side_r[0] <= side_in;
      // stage 2: blocks = ceil(num / 4k) by reciprocal
      prod_r    <= {5'd0, n_r} * {12'd0, toa_pkg::toa_recip(cfg.k)};
      side_r[1] <= side_r[0];
      // stage 3: symbol count
      nsyms_r   <= 11'd8 + {3'd0, prod_r[27:20]} * {7'd0, cfg.cr};
      side_r[2] <= side_r[1];
      // stage 4: payload time
      pay_r     <= {36'd0, nsyms_r} * {11'd0, cfg.tsym};
      side_r[3] <= side_r[2];
      // stage 5: total plus half microsecond, ns / 8 into the divider
      x_r       <= {1'b0, total[41:3]};
      side_r[4] <= '{us: 32'd0, ldro: side_r[3].ldro, invalid: side_r[3].invalid,
                     sat: (total >= toa_pkg::US_SAT_LIMIT)};
    end
  end

  assign out_valid = v_r[4];
  assign out_x     = x_r;
  assign out_side  = side_r[4];

endmodule

`default_nettype wire

>>> rtl/toa_div125.sv
// ----------------------------------------------------------------------------
// toa_div125: pipelined divide by 125
// One 4-bit quotient digit per stage, most significant first, with the
// sideband record carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module toa_div125 (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [toa_pkg::DIV_W-1:0] in_x,
  input  wire toa_pkg::toa_side_t       in_side,
  output logic                          out_valid,
  output logic [toa_pkg::DIV_W-1:0]     out_q,
  output toa_pkg::toa_side_t            out_side
);

  localparam int N = toa_pkg::DIV_STAGES;
  localparam int W = toa_pkg::DIV_W;
  localparam int D = toa_pkg::DIGIT_W;
  localparam int R = toa_pkg::REM_W;
  localparam int V = R + D;

  logic [W-1:0]       x_w   [N+1];
  logic [R-1:0]       rem_w [N+1];
  toa_pkg::toa_side_t side_w[N+1];
  logic [N:0]         v_w;

  assign x_w[0]    = in_x;
  assign rem_w[0]  = '0;
  assign side_w[0] = in_side;
  assign v_w[0]    = in_valid;

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [V-1:0] val;
    logic [D-1:0] dig;
    logic [W-1:0] x_nxt;
    logic [R-1:0] rem_nxt;
    logic [W-1:0] x_r;
    logic [R-1:0] rem_r;
    toa_pkg::toa_side_t side_r;
    logic         v_r;

    // pick the largest digit whose multiple of 125 fits
    always_comb begin
      val = {rem_w[j], x_w[j][W-1-D*j -: D]};
      dig = '0;
      for (int d = 1; d < (1 << D); d++) begin
        if (val >= V'(d * 125)) dig = D'(d);
      end
      rem_nxt = R'(val - V'(dig) * V'(125));
      x_nxt   = x_w[j];
      x_nxt[W-1-D*j -: D] = dig;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r    <= x_nxt;
        rem_r  <= rem_nxt;
        side_r <= side_w[j];
      end
    end

    assign x_w[j+1]    = x_r;
    assign rem_w[j+1]  = rem_r;
    assign side_w[j+1] = side_r;
    assign v_w[j+1]    = v_r;
  end

  assign out_valid = v_w[N];
  assign out_q     = x_w[N];
  assign out_side  = side_w[N];

endmodule

`default_nettype wire
